// File: rtl/sobel_pkg.sv
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared widths, register indexes and reset values for the Sobel stream unit.
// ----------------------------------------------------------------------------
package sobel_pkg;

	localparam int PIX_W      = 8;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 16;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int IMG_WIDTH_RST  = 750;
	localparam int IMG_HEIGHT_RST = 500;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	typedef logic [PIX_W-1:0]      pix_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;
	typedef logic [HEIGHT_W-1:0]   row_t;

endpackage

// File: rtl/sobel_if.sv
// ----------------------------------------------------------------------------
// sobel_if
// Valid/ready channels of the Sobel stream unit: pixels, gradients, config.
// ----------------------------------------------------------------------------
interface pix_stream_if;
	logic                 valid;
	logic                 ready;
	sobel_pkg::pix_t      pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

interface grad_stream_if;
	logic                 valid;
	logic                 ready;
	sobel_pkg::pix_t      horizontal_gradient;
	sobel_pkg::pix_t      vertical_gradient;
	logic                 frame_last;

	modport source (output valid, output horizontal_gradient, output vertical_gradient,
		output frame_last, input ready);
	modport sink   (input valid, input horizontal_gradient, input vertical_gradient,
		input frame_last, output ready);
endinterface

interface cfg_write_if;
	logic                 valid;
	logic                 ready;
	sobel_pkg::cfg_idx_t  index;
	sobel_pkg::cfg_data_t data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/sobel_3x3_gradient_stream_unit.sv
// ----------------------------------------------------------------------------
// sobel_3x3_gradient_stream_unit
// Streaming 3x3 Sobel filter: raster pixels in, Gx/Gy bytes (offset 128) out.
// ----------------------------------------------------------------------------
//
//  channel        | dir | payload                                      | note
//  ---------------+-----+----------------------------------------------+-------------------
//  pixels_in      | in  | pixel[7:0]                                   | one per transaction
//  gradients_out  | out | horizontal_gradient, vertical_gradient,      | interior pixels only
//                 |     | frame_last                                   |
//  cfg            | in  | index[7:0], data[15:0]                       | always ready
//
//  One pixel per clock sustained while gradients_out does not stall. The pipeline is
//  the line store read (s1), then the tap sum into the output register (s2).
//  The line store is a single 16-bit wide memory holding both previous rows
//  per column, read on accept and written back when the pixel leaves s1.
//  Border pixels produce no transaction and never wait on the output side.
//  s1 and the output register each hold one transaction, so a pixel is still
//  accepted while a result waits; ready drops only when both are full.
//  arst_n clears counters, window and valids; the line store is not cleared:
//  stale entries read in the first two rows of a frame only feed border pixels.
//  A write to the width or height register restarts the frame (column and row go to zero).
//
module sobel_3x3_gradient_stream_unit #(
	parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	pix_stream_if.sink           pixels_in,
	grad_stream_if.source        gradients_out,
	cfg_write_if.sink            cfg
);
	import sobel_pkg::*;

	localparam int AW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int RST_W = (IMG_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : IMG_WIDTH_RST;
	localparam logic [AW-1:0] COL_LAST_RST = AW'(RST_W - 1);
	localparam row_t          ROW_LAST_RST = HEIGHT_W'(IMG_HEIGHT_RST - 1);

	typedef logic [AW-1:0] col_t;

	// geometry, held as last column / last row
	col_t col_last_q;
	row_t row_last_q;

	// raster position of the next pixel
	col_t col_q;
	row_t row_q;

	// stage 1: pixel plus line store read
	logic                  s1_v_q;
	logic                  prod_s1;
	logic                  last_s1;
	pix_t                  pix_s1;
	col_t                  col_s1;
	logic [2*PIX_W-1:0]    rd_s1;   // [15:8] older row, [7:0] newer row

	// window: [row][col], row 0 oldest line, col 0 oldest column
	pix_t win_q [3][3];
	pix_t win_nx [3][3];

	// output register
	logic out_v_s2;
	pix_t hgrad_s2;
	pix_t vgrad_s2;
	logic last_s2;

	logic [2*PIX_W-1:0] row_pair_mem [MAX_WIDTH];

	logic in_acc, cfg_acc, s1_adv, out_free, produce, frame_end;
	logic [WIDTH_W-1:0] cfg_w;
	row_t               cfg_h;
	logic [9:0]         gx_pos, gx_neg, gy_pos, gy_neg, gx_sum, gy_sum;

	// ---------------- handshakes ----------------
	assign cfg.ready   = 1'b1;
	assign cfg_acc     = cfg.valid;
	assign out_free    = !out_v_s2 || gradients_out.ready;
	assign s1_adv      = s1_v_q && (!prod_s1 || out_free);
	assign pixels_in.ready = !s1_v_q || s1_adv;
	assign in_acc      = pixels_in.valid && pixels_in.ready;

	// interior test and frame end for the pixel being accepted
	assign produce   = (row_q[HEIGHT_W-1:1] != '0) && (col_q >= AW'(2));
	assign frame_end = (row_q == row_last_q) && (col_q == col_last_q);

	// width clamped to 3..MAX_WIDTH, height to at least 3
	assign cfg_w = cfg.data[WIDTH_W-1:0];
	assign cfg_h = cfg.data[HEIGHT_W-1:0];

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_last_q <= COL_LAST_RST;
			row_last_q <= ROW_LAST_RST;
			col_q      <= '0;
			row_q      <= '0;
			s1_v_q     <= 1'b0;
			prod_s1    <= 1'b0;
			last_s1    <= 1'b0;
			out_v_s2   <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else begin
			if (cfg_acc) begin
				unique case (cfg.index)
					REG_IMAGE_WIDTH: begin
						if (cfg_w < WIDTH_W'(3))
							col_last_q <= AW'(2);
						else if (32'(cfg_w) > MAX_WIDTH)
							col_last_q <= AW'(MAX_WIDTH - 1);
						else
							col_last_q <= AW'(cfg_w - WIDTH_W'(1));
						col_q <= '0;
						row_q <= '0;
					end
					REG_IMAGE_HEIGHT: begin
						row_last_q <= (cfg_h < HEIGHT_W'(3)) ? HEIGHT_W'(2)
							: cfg_h - HEIGHT_W'(1);
						col_q <= '0;
						row_q <= '0;
					end
					default: ;
				endcase
			end else if (in_acc) begin
				if (col_q == col_last_q) begin
					col_q <= '0;
					row_q <= (row_q == row_last_q) ? '0 : row_q + HEIGHT_W'(1);
				end else begin
					col_q <= col_q + AW'(1);
				end
			end

			if (in_acc) begin
				s1_v_q  <= 1'b1;
				prod_s1 <= produce;
				last_s1 <= frame_end;
			end else if (s1_adv) begin
				s1_v_q  <= 1'b0;
			end

			if (s1_adv) begin
				win_q <= win_nx;
			end

			if (s1_adv && prod_s1)
				out_v_s2 <= 1'b1;
			else if (gradients_out.ready)
				out_v_s2 <= 1'b0;
		end
	end

	// ---------------- line store and payload ----------------
	always_ff @(posedge clk) begin
		if (s1_adv)
			row_pair_mem[col_s1] <= {rd_s1[PIX_W-1:0], pix_s1};
		if (in_acc) begin
			rd_s1  <= row_pair_mem[col_q];
			pix_s1 <= pixels_in.pixel;
			col_s1 <= col_q;
		end
		if (s1_adv && prod_s1) begin
			hgrad_s2 <= gx_sum[PIX_W-1:0];
			vgrad_s2 <= gy_sum[PIX_W-1:0];
			last_s2  <= last_s1;
		end
	end

	// ---------------- window shift and taps ----------------
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_nx[i][0] = win_q[i][1];
			win_nx[i][1] = win_q[i][2];
		end
		win_nx[0][2] = rd_s1[2*PIX_W-1:PIX_W];
		win_nx[1][2] = rd_s1[PIX_W-1:0];
		win_nx[2][2] = pix_s1;
	end

	// weight 1 tap is p>>3, weight 2 tap is p>>2 (truncation toward zero)
	always_comb begin
		gx_pos = 10'(win_nx[0][2] >> 3) + 10'(win_nx[1][2] >> 2) + 10'(win_nx[2][2] >> 3);
		gx_neg = 10'(win_nx[0][0] >> 3) + 10'(win_nx[1][0] >> 2) + 10'(win_nx[2][0] >> 3);
		gy_pos = 10'(win_nx[2][0] >> 3) + 10'(win_nx[2][1] >> 2) + 10'(win_nx[2][2] >> 3);
		gy_neg = 10'(win_nx[0][0] >> 3) + 10'(win_nx[0][1] >> 2) + 10'(win_nx[0][2] >> 3);
		gx_sum = 10'd128 + gx_pos - gx_neg;
		gy_sum = 10'd128 + gy_pos - gy_neg;
	end

	assign gradients_out.valid               = out_v_s2;
	assign gradients_out.horizontal_gradient = hgrad_s2;
	assign gradients_out.vertical_gradient   = vgrad_s2;
	assign gradients_out.frame_last          = last_s2;

	// ---------------- assertions ----------------
	// write-back and the new read never hit the same column
	a_no_col_clash: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && s1_adv |-> col_q != col_s1)
		else $error("line store read and write-back on the same column");

	// column counter stays inside the configured row
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= col_last_q)
		else $error("column counter beyond last column");

	// offset sums cannot leave 3..253
	a_grad_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_s2 |-> hgrad_s2 >= 8'd3 && hgrad_s2 <= 8'd253
			&& vgrad_s2 >= 8'd3 && vgrad_s2 <= 8'd253)
		else $error("gradient outside 3..253");

	// a border pixel never loads the output register
	a_border_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && !prod_s1 && !out_v_s2 |=> !out_v_s2)
		else $error("result from a border pixel");

endmodule
